/* rtl/core/pidc_pkg.sv */
`default_nettype none

package pidc_pkg;

	// Fixed-point format of the gains
	localparam int FRAC_BITS = 12;

	// Field and register widths
	localparam int MEAS_W   = 16;
	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 31;
	localparam int DRIVE_W  = 32;
	localparam int ERR_W    = MEAS_W + 1;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Register reset values
	localparam logic [LIMIT_W-1:0]        INTEG_LIMIT_RST = 31'd1000;
	localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST = 32'sd1000;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST = -32'sd1000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET      = 3'd0,
		REG_PROP_GAIN   = 3'd1,
		REG_INTEG_GAIN  = 3'd2,
		REG_DERIV_GAIN  = 3'd3,
		REG_INTEG_LIMIT = 3'd4,
		REG_DRIVE_UPPER = 3'd5,
		REG_DRIVE_LOWER = 3'd6
	} cfg_idx_t;

endpackage

`default_nettype wire

/* rtl/core/pid_controller_clamped.sv */
`default_nettype none

// Positional PID controller with anti-windup clamp. Each input beat carries
// one signed feedback sample; the block forms error = target_value - measured,
// adds (integ_gain*error)>>12 to its stored integral (clamped to
// +-integ_limit), and returns (prop_gain*error)>>12 + integral +
// (deriv_gain*(error - previous error))>>12 clamped to [drive_lower,
// drive_upper], one output beat per input beat. Gains are signed Q12 and each
// product is shifted (floor) on its own. The block takes one beat per clock
// while the output side accepts; a result passes from the input register
// through the three multipliers and the integral and drive clamps into the
// output register. Reset clears the integral and the previous error; the
// user must write registers only while no beat is in flight, which the
// block itself does not enforce.
module pid_controller_clamped
	import pidc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// slave side: tdata = measured[15:0]
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [MEAS_W-1:0]    s_axis_tdata,
	// master side: tdata = drive[31:0]
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [DRIVE_W-1:0]        m_axis_tdata,
	// configuration write port
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	// Configuration registers
	logic signed [MEAS_W-1:0]  target_q;
	logic signed [GAIN_W-1:0]  prop_gain_q;
	logic signed [GAIN_W-1:0]  integ_gain_q;
	logic signed [GAIN_W-1:0]  deriv_gain_q;
	logic [LIMIT_W-1:0]        integ_limit_q;
	logic signed [DRIVE_W-1:0] drive_upper_q;
	logic signed [DRIVE_W-1:0] drive_lower_q;

	// Controller state
	logic signed [DRIVE_W-1:0] integ_sum_q;
	logic signed [ERR_W-1:0]   prev_err_q;

	// Input and output registers
	logic                      valid_s1;
	logic signed [MEAS_W-1:0]  meas_s1;
	logic                      valid_s2;
	logic [DRIVE_W-1:0]        drive_s2;

	logic                      advance;

	// Datapath signals
	logic signed [ERR_W-1:0]         err;
	logic signed [DIFF_W-1:0]        diff;
	logic signed [GAIN_W+ERR_W-1:0]  prop_prod;
	logic signed [GAIN_W+ERR_W-1:0]  integ_prod;
	logic signed [GAIN_W+DIFF_W-1:0] deriv_prod;
	logic signed [GAIN_W+ERR_W-FRAC_BITS-1:0]  prop_sh;
	logic signed [GAIN_W+ERR_W-FRAC_BITS-1:0]  integ_sh;
	logic signed [GAIN_W+DIFF_W-FRAC_BITS-1:0] deriv_sh;
	logic signed [DRIVE_W:0]   lim_pos;
	logic signed [DRIVE_W:0]   lim_neg;
	logic signed [DRIVE_W:0]   integ_raw;
	logic signed [DRIVE_W-1:0] integ_new;
	logic signed [DRIVE_W+1:0] sum_raw;
	logic signed [DRIVE_W+1:0] sum_clamped;

	// Handshake: the input register moves on when the output register is free
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = drive_s2;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= '0;
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			integ_limit_q <= INTEG_LIMIT_RST;
			drive_upper_q <= DRIVE_UPPER_RST;
			drive_lower_q <= DRIVE_LOWER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TARGET:      target_q      <= cfg_wdata[MEAS_W-1:0];
				REG_PROP_GAIN:   prop_gain_q   <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG_LIMIT: integ_limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_DRIVE_UPPER: drive_upper_q <= cfg_wdata[DRIVE_W-1:0];
				REG_DRIVE_LOWER: drive_lower_q <= cfg_wdata[DRIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Error and its change since the last sample
	always_comb begin
		err  = ERR_W'(target_q) - ERR_W'(meas_s1);
		diff = DIFF_W'(err) - DIFF_W'(prev_err_q);
	end

	// Gain products, each floored by the Q12 shift
	always_comb begin
		prop_prod  = (GAIN_W+ERR_W)'(prop_gain_q) * (GAIN_W+ERR_W)'(err);
		integ_prod = (GAIN_W+ERR_W)'(integ_gain_q) * (GAIN_W+ERR_W)'(err);
		deriv_prod = (GAIN_W+DIFF_W)'(deriv_gain_q) * (GAIN_W+DIFF_W)'(diff);
		prop_sh    = prop_prod[GAIN_W+ERR_W-1:FRAC_BITS];
		integ_sh   = integ_prod[GAIN_W+ERR_W-1:FRAC_BITS];
		deriv_sh   = deriv_prod[GAIN_W+DIFF_W-1:FRAC_BITS];
	end

	// Integral update with anti-windup clamp, upper bound first
	always_comb begin
		lim_pos   = (DRIVE_W+1)'(integ_limit_q);
		lim_neg   = -lim_pos;
		integ_raw = (DRIVE_W+1)'(integ_sum_q) + (DRIVE_W+1)'(integ_sh);
		priority if (integ_raw > lim_pos) begin
			integ_new = DRIVE_W'(lim_pos);
		end else if (integ_raw < lim_neg) begin
			integ_new = DRIVE_W'(lim_neg);
		end else begin
			integ_new = DRIVE_W'(integ_raw);
		end
	end

	// Output sum and drive clamp, upper bound first
	always_comb begin
		sum_raw = (DRIVE_W+2)'(prop_sh) + (DRIVE_W+2)'(integ_new)
			+ (DRIVE_W+2)'(deriv_sh);
		priority if (sum_raw > (DRIVE_W+2)'(drive_upper_q)) begin
			sum_clamped = (DRIVE_W+2)'(drive_upper_q);
		end else if (sum_raw < (DRIVE_W+2)'(drive_lower_q)) begin
			sum_clamped = (DRIVE_W+2)'(drive_lower_q);
		end else begin
			sum_clamped = sum_raw;
		end
	end

	// Control: valid flags and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			integ_sum_q <= '0;
			prev_err_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2    <= 1'b1;
				integ_sum_q <= integ_new;
				prev_err_q  <= err;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			meas_s1 <= s_axis_tdata;
		end
		if (advance) begin
			drive_s2 <= sum_clamped[DRIVE_W-1:0];
		end
	end

	// Assertions
	a_integ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ((DRIVE_W+1)'(integ_sum_q) <= $past(lim_pos))
			&& ((DRIVE_W+1)'(integ_sum_q) >= $past(lim_neg)))
		else $error("integral left its clamp range");

	a_prev_err: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (prev_err_q == $past(err)))
		else $error("previous error not taken from the last beat");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("result lost after the single pass");

	a_drive_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (drive_lower_q <= drive_upper_q)) |->
			(($signed(m_axis_tdata) <= drive_upper_q)
			&& ($signed(m_axis_tdata) >= drive_lower_q)))
		else $error("drive outside its bounds");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import pidc_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int LATENCY      = 2;
	localparam int LIMIT_CYCLES = 200000;
	localparam int NPHASE       = 10;
	localparam int PHASE_ITEMS  = 100;
	localparam int QUIET_PHASE  = 4;
	localparam int HOLD_PHASE   = 2;
	localparam int LONG_HOLD    = 300;

	// index outside the register map, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     wdata;
		logic [MEAS_W-1:0]    meas;
		logic                 typed;
		logic [DRIVE_W-1:0]   drive;
	} step_row_t;

	localparam int NDIR = 43;

	// directed walk: settings and samples, typed drive only where obvious
	localparam step_row_t DIR_TAB [NDIR] = '{
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd32767,  1'b1, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd32768, 1'b1, 32'sd0},
		'{ROW_CFG,    REG_PROP_GAIN,   32'd4096,      16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd32768, 1'b1, 32'sd1000},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd32767,  1'b1, -32'sd1000},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd0,      1'b1, 32'sd0},
		'{ROW_CFG,    REG_UNUSED,      32'h0000_1000, 16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd100,    1'b1, -32'sd100},
		'{ROW_CFG,    REG_PROP_GAIN,   32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_INTEG_GAIN,  32'd4096,      16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd500,   1'b1, 32'sd500},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd500,   1'b1, 32'sd1000},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd500,   1'b1, 32'sd1000},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd2000,   1'b1, -32'sd1000},
		'{ROW_CFG,    REG_INTEG_LIMIT, 32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd7,      1'b1, 32'sd0},
		'{ROW_CFG,    REG_INTEG_GAIN,  32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_DERIV_GAIN,  32'd4096,      16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd0,      1'b1, 32'sd7},
		'{ROW_CFG,    REG_INTEG_LIMIT, 32'h7FFF_FFFF, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_DRIVE_UPPER, 32'h7FFF_FFFF, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_DRIVE_LOWER, 32'h8000_0000, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_TARGET,      32'h0000_7FFF, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_PROP_GAIN,   32'h007F_FFFF, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_INTEG_GAIN,  32'h007F_FFFF, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_DERIV_GAIN,  32'h0080_0000, 16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd32768, 1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd32768, 1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd32767,  1'b0, 32'sd0},
		'{ROW_CFG,    REG_TARGET,      32'hFFFF_8000, 16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd32767,  1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd32768, 1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd32767,  1'b0, 32'sd0},
		'{ROW_CFG,    REG_DRIVE_UPPER, 32'hFFFF_FFFB, 16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_DRIVE_LOWER, 32'd5,         16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_PROP_GAIN,   32'd4096,      16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_INTEG_GAIN,  32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_DERIV_GAIN,  32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_INTEG_LIMIT, 32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_CFG,    REG_TARGET,      32'd0,         16'd0,       1'b0, 32'sd0},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd10,     1'b1, 32'sd5},
		'{ROW_SAMPLE, 3'd0,            32'd0,         -16'sd10,    1'b1, -32'sd5},
		'{ROW_SAMPLE, 3'd0,            32'd0,         16'sd5,      1'b1, 32'sd5}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [MEAS_W-1:0]    s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [DRIVE_W-1:0]   m_axis_tdata;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// shadow of the register file
	logic signed [MEAS_W-1:0]  set_target = '0;
	logic signed [GAIN_W-1:0]  set_kp     = '0;
	logic signed [GAIN_W-1:0]  set_ki     = '0;
	logic signed [GAIN_W-1:0]  set_kd     = '0;
	logic [LIMIT_W-1:0]        set_ilim   = INTEG_LIMIT_RST;
	logic signed [DRIVE_W-1:0] set_dhi    = DRIVE_UPPER_RST;
	logic signed [DRIVE_W-1:0] set_dlo    = DRIVE_LOWER_RST;

	// controller state as the block should hold it
	logic signed [DRIVE_W-1:0] pred_integ    = '0;
	logic signed [ERR_W-1:0]   pred_prev_err = '0;

	logic [DRIVE_W-1:0] drive_due [$];
	logic [DRIVE_W-1:0] due_head;

	bit idle_on       = 1'b1;
	bit long_hold_req = 1'b0;
	int n_err         = 0;
	int n_samples     = 0;
	int n_drives      = 0;
	int n_writes      = 0;
	int cycle_cnt     = 0;

	pid_controller_clamped dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // measured[15:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // drive[31:0]
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one control step: error, clamped integral, clamped drive
	function automatic logic [DRIVE_W-1:0] pid_predict(input logic signed [MEAS_W-1:0] meas);
		longint err;
		longint prop;
		longint integ;
		longint deriv;
		longint sum;
		longint lim;
		err   = longint'(set_target) - longint'(meas);
		prop  = (longint'(set_kp) * err) >>> FRAC_BITS;
		integ = longint'(pred_integ) + ((longint'(set_ki) * err) >>> FRAC_BITS);
		lim   = longint'({1'b0, set_ilim});
		if (integ > lim) begin
			integ = lim;
		end else if (integ < -lim) begin
			integ = -lim;
		end
		pred_integ = 32'(integ);
		deriv = (longint'(set_kd) * (err - longint'(pred_prev_err))) >>> FRAC_BITS;
		sum   = prop + integ + deriv;
		// upper test first, matters when the bounds are inverted
		if (sum > longint'(set_dhi)) begin
			sum = set_dhi;
		end else if (sum < longint'(set_dlo)) begin
			sum = set_dlo;
		end
		pred_prev_err = 17'(err);
		return 32'(sum);
	endfunction

	function automatic logic [CFG_W-1:0] rand_gain();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($urandom_range(0, 16383)) - 32'd8192;
			2: return $urandom_range(0, 1) ? 32'h007F_FFFF : 32'h0080_0000;
			default: return 32'($urandom_range(3000, 5000));
		endcase
	endfunction

	// register write, only once every drive beat has come back
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (drive_due.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_TARGET:      set_target = val[MEAS_W-1:0];
			REG_PROP_GAIN:   set_kp     = val[GAIN_W-1:0];
			REG_INTEG_GAIN:  set_ki     = val[GAIN_W-1:0];
			REG_DERIV_GAIN:  set_kd     = val[GAIN_W-1:0];
			REG_INTEG_LIMIT: set_ilim   = val[LIMIT_W-1:0];
			REG_DRIVE_UPPER: set_dhi    = val;
			REG_DRIVE_LOWER: set_dlo    = val;
			default: ;
		endcase
		n_writes++;
	endtask

	// offer one sample beat, book its drive once taken
	task automatic send_sample(input logic [MEAS_W-1:0] meas, input logic typed,
			input logic [DRIVE_W-1:0] typed_drive);
		int gap;
		logic [DRIVE_W-1:0] want;
		cfg_wr_en <= 1'b0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= meas;
		do @(posedge clk); while (!s_axis_tready);
		want = pid_predict(meas);
		drive_due.push_back(typed ? typed_drive : want);
		n_samples++;
	endtask

	// output side: random stalls plus one long hold-off
	initial begin : out_side
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// drive beats against the oldest booked value
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drive_due.size() == 0) begin
				$display("%0t: drive beat with nothing due, expected none, got %0d",
					$time, $signed(m_axis_tdata));
				n_err++;
			end else begin
				due_head = drive_due.pop_front();
				if (m_axis_tdata !== due_head) begin
					$display("%0t: drive mismatch, expected %0d, got %0d",
						$time, $signed(due_head), $signed(m_axis_tdata));
					n_err++;
				end
				n_drives++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin : stim
		int phase;
		int k;
		logic [CFG_W-1:0]    target_w;
		logic [CFG_W-1:0]    lim_w;
		logic [CFG_W-1:0]    dhi_w;
		logic [CFG_W-1:0]    dlo_w;
		logic [MEAS_W-1:0]   meas;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < NDIR; r++) begin
			if (DIR_TAB[r].kind == ROW_CFG) begin
				cfg_write(DIR_TAB[r].idx, DIR_TAB[r].wdata);
			end else begin
				send_sample(DIR_TAB[r].meas, DIR_TAB[r].typed, DIR_TAB[r].drive);
			end
		end

		// random phases, each under fresh settings
		for (phase = 0; phase < NPHASE; phase++) begin
			idle_on = (phase != QUIET_PHASE) && (phase != NPHASE - 1);
			target_w = $urandom_range(0, 1) ? $urandom()
				: 32'($urandom_range(0, 2000)) - 32'd1000;
			case ($urandom_range(0, 3))
				0: lim_w = $urandom();
				1: lim_w = 32'($urandom_range(0, 5000));
				2: lim_w = 32'd0;
				default: lim_w = 32'h7FFF_FFFF;
			endcase
			case ($urandom_range(0, 3))
				0: begin
					dhi_w = 32'($urandom_range(0, 20000));
					dlo_w = 32'd0 - 32'($urandom_range(0, 20000));
				end
				1: begin
					dhi_w = $urandom();
					dlo_w = $urandom();
				end
				2: begin
					dhi_w = 32'h7FFF_FFFF;
					dlo_w = 32'h8000_0000;
				end
				default: begin
					// inverted bounds
					dhi_w = 32'd0 - 32'($urandom_range(1, 500));
					dlo_w = 32'($urandom_range(1, 500));
				end
			endcase
			cfg_write(REG_TARGET, target_w);
			cfg_write(REG_PROP_GAIN, rand_gain());
			cfg_write(REG_INTEG_GAIN, rand_gain());
			cfg_write(REG_DERIV_GAIN, rand_gain());
			cfg_write(REG_INTEG_LIMIT, lim_w);
			cfg_write(REG_DRIVE_UPPER, dhi_w);
			cfg_write(REG_DRIVE_LOWER, dlo_w);
			if ($urandom_range(0, 2) == 0)
				cfg_write(REG_UNUSED, $urandom());

			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == HOLD_PHASE && k == 20)
					long_hold_req = 1'b1;
				// half the samples close to the setpoint, the rest anywhere
				if ($urandom_range(0, 1))
					meas = set_target + 16'($urandom_range(0, 600)) - 16'd300;
				else
					meas = 16'($urandom());
				send_sample(meas, 1'b0, '0);
			end
		end

		// drain, then keep watching the output to catch stray beats
		s_axis_tvalid <= 1'b0;
		while (drive_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display("summary: %0d samples in, %0d drive beats checked, %0d register writes",
			n_samples, n_drives, n_writes);
		$display("summary: %0d random setting phases, one long output hold-off", NPHASE);
		if (n_err == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
